>>> sv/crop_feasibility_shrink_core_defines.svh
// Assertion macros used by the checker file.
`ifndef CROP_FEASIBILITY_SHRINK_CORE_DEFINES_SVH
`define CROP_FEASIBILITY_SHRINK_CORE_DEFINES_SVH

// cons must hold in any cycle where ante holds
`define CFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// expr must never hold
`define CFS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

>>> sv/cfs_pkg.sv
`default_nettype none
package cfs_pkg;

    localparam int unsigned DIV_STEPS  = 16;
    localparam int unsigned DIV_LAT    = DIV_STEPS + 3;
    localparam int unsigned FRONT_LAT  = 4;
    localparam int unsigned BACK_LAT   = 4;
    localparam int unsigned PIPE_DEPTH = FRONT_LAT + DIV_LAT + BACK_LAT;
    localparam int unsigned NUM_BOUNDS = 10;
    localparam int unsigned NUM_MIN1   = NUM_BOUNDS / 2;
    localparam int unsigned DLY_LEN    = DIV_LAT + 2;

    localparam logic [16:0] LAM_ONE   = 17'h10000;
    localparam logic [14:0] DIM_MAX   = 15'd16384;
    localparam logic [16:0] RATIO_MAX = 17'd65536;
    localparam logic signed [63:0] ONE_Q16 = 64'sd65536;

    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CROP_RATIO   = 3'd2;
    localparam logic [2:0] REG_MIN_SCALE    = 3'd3;
    localparam logic [2:0] REG_MAX_SCALE    = 3'd4;
    localparam logic [2:0] REG_MAX_SKEW     = 3'd5;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               last;
    } t_xform;

    // one violated-bound check: factor = num / |d|
    typedef struct packed {
        logic               act;
        logic               neg;
        logic signed [63:0] num;
        logic signed [63:0] d;
    } t_bound;

endpackage
`default_nettype wire

>>> sv/cfs_div.sv
`default_nettype none
module cfs_div (
    input  logic            i_clk,
    input  cfs_pkg::t_bound i_bound,
    output logic [16:0]     o_factor
);
    import cfs_pkg::*;

    logic               r_act1;
    logic signed [63:0] r_num1;
    logic [62:0]        r_den1;
    logic signed [63:0] n_mag;

    logic [62:0] r_rem  [DIV_STEPS+1];
    logic [62:0] r_den  [DIV_STEPS+1];
    logic [15:0] r_q    [DIV_STEPS+1];
    logic        r_fix  [DIV_STEPS+1];
    logic [16:0] r_fval [DIV_STEPS+1];
    logic [16:0] r_out;

    logic n_le0;
    logic n_ge;

    assign n_mag = i_bound.neg ? -i_bound.d : i_bound.d;

    always_ff @(posedge i_clk) begin
        r_act1 <= i_bound.act;
        r_num1 <= i_bound.num;
        r_den1 <= n_mag[62:0];
    end

    // quotient saturates to 0 or one outside the open interval
    assign n_le0 = r_num1[63] || (r_num1 == '0);
    assign n_ge  = !n_le0 && (r_num1[62:0] >= r_den1);

    always_ff @(posedge i_clk) begin
        r_fix[0]  <= !r_act1 || n_le0 || n_ge;
        r_fval[0] <= (!r_act1 || n_ge) ? LAM_ONE : 17'd0;
        r_rem[0]  <= r_num1[62:0];
        r_den[0]  <= r_den1;
        r_q[0]    <= '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [63:0] w_sh;
        logic [63:0] w_diff;
        logic        w_ge;
        assign w_sh   = {r_rem[k], 1'b0};
        assign w_ge   = w_sh >= {1'b0, r_den[k]};
        assign w_diff = w_sh - {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= w_ge ? w_diff[62:0] : w_sh[62:0];
            r_den[k+1]  <= r_den[k];
            r_q[k+1]    <= {r_q[k][14:0], w_ge};
            r_fix[k+1]  <= r_fix[k];
            r_fval[k+1] <= r_fval[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= r_fix[DIV_STEPS] ? r_fval[DIV_STEPS] : {1'b0, r_q[DIV_STEPS]};
    end

    assign o_factor = r_out;

endmodule
`default_nettype wire

>>> sv/crop_feasibility_shrink_core.sv
// One transaction is accepted per cycle; busy stays low, results cannot be held off.
// The 16 restoring-division stages of the ten bound dividers set most of the depth.
// Reset (synchronous, active low) clears the in-flight valid bits and loads the
// default configuration; items in flight are dropped.
`default_nettype none
module crop_feasibility_shrink_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_shift_x,
    input  logic signed [31:0] i_shift_y,
    input  logic signed [31:0] i_coef_a,
    input  logic signed [31:0] i_coef_b,
    input  logic               i_last_frame,
    output logic               o_valid,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_a,
    output logic signed [31:0] o_out_b,
    output logic [16:0]        o_shrink_factor,
    output logic               o_was_shrunk,
    output logic               o_last_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import cfs_pkg::*;

    function automatic t_bound f_bound(input logic signed [63:0] cur,
                                       input logic signed [63:0] idv,
                                       input logic signed [63:0] lo,
                                       input logic signed [63:0] up);
        logic signed [63:0] d;
        logic               hi;
        logic               lw;
        t_bound             bnd;
        d        = cur - idv;
        hi       = (d > 0) && (cur > up);
        lw       = (d < 0) && (cur < lo);
        bnd.act  = hi || lw;
        bnd.neg  = lw;
        bnd.num  = hi ? (up - idv) : (idv - lo);
        bnd.d    = d;
        return bnd;
    endfunction

    // configuration
    logic [14:0] r_frame_width;
    logic [14:0] r_frame_height;
    logic [16:0] r_crop_ratio;
    logic [30:0] r_min_scale;
    logic [30:0] r_max_scale;
    logic [16:0] r_max_skew;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 15'd1920;
            r_frame_height <= 15'd1080;
            r_crop_ratio   <= 17'd59578;
            r_min_scale    <= 31'd65536;
            r_max_scale    <= 31'd72090;
            r_max_skew     <= 17'd6554;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[14:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[14:0];
                REG_CROP_RATIO:   r_crop_ratio   <= i_cfg_data[16:0];
                REG_MIN_SCALE:    r_min_scale    <= i_cfg_data[30:0];
                REG_MAX_SCALE:    r_max_scale    <= i_cfg_data[30:0];
                REG_MAX_SKEW:     r_max_skew     <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // derived crop geometry, refreshed every cycle
    logic [14:0] n_fw_s;
    logic [14:0] n_fh_s;
    logic [16:0] n_cr_s;
    logic [31:0] n_cw;
    logic [31:0] n_ch;
    logic [14:0] r_fw_s;
    logic [14:0] r_fh_s;
    logic [30:0] r_cw;
    logic [30:0] r_ch;

    assign n_fw_s = (r_frame_width > DIM_MAX) ? DIM_MAX : r_frame_width;
    assign n_fh_s = (r_frame_height > DIM_MAX) ? DIM_MAX : r_frame_height;
    assign n_cr_s = (r_crop_ratio > RATIO_MAX) ? RATIO_MAX : r_crop_ratio;
    assign n_cw   = 32'(n_fw_s) * 32'(n_cr_s);
    assign n_ch   = 32'(n_fh_s) * 32'(n_cr_s);

    always_ff @(posedge i_clk) begin
        r_fw_s <= n_fw_s;
        r_fh_s <= n_fh_s;
        r_cw   <= n_cw[30:0];
        r_ch   <= n_ch[30:0];
    end

    // valid bits
    logic                  w_acc;
    logic [PIPE_DEPTH-1:0] r_vld;

    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], w_acc};
        end
    end

    // stage 1: capture
    t_xform r_s1;
    always_ff @(posedge i_clk) begin
        r_s1 <= '{x: i_shift_x, y: i_shift_y, a: i_coef_a, b: i_coef_b,
                  last: i_last_frame};
    end

    // stage 2: products of a, b with the crop sizes
    logic signed [31:0] w_cw_s;
    logic signed [31:0] w_ch_s;
    logic signed [63:0] n_acw;
    logic signed [63:0] n_ach;
    logic signed [63:0] n_bcw;
    logic signed [63:0] n_bch;
    logic signed [63:0] r_acw;
    logic signed [63:0] r_ach;
    logic signed [63:0] r_bcw;
    logic signed [63:0] r_bch;
    t_xform             r_s2;

    assign w_cw_s = signed'({1'b0, r_cw});
    assign w_ch_s = signed'({1'b0, r_ch});
    assign n_acw  = r_s1.a * w_cw_s;
    assign n_ach  = r_s1.a * w_ch_s;
    assign n_bcw  = r_s1.b * w_cw_s;
    assign n_bch  = r_s1.b * w_ch_s;

    always_ff @(posedge i_clk) begin
        r_acw <= n_acw;
        r_ach <= n_ach;
        r_bcw <= n_bcw;
        r_bch <= n_bch;
        r_s2  <= r_s1;
    end

    // stages 3 and 4: corner images, then the bound checks
    logic signed [63:0] w_xs;
    logic signed [63:0] w_ys;
    logic signed [63:0] w_cwq;
    logic signed [63:0] w_chq;
    logic signed [63:0] w_bx;
    logic signed [63:0] w_by;
    logic signed [63:0] r_px [4];
    logic signed [63:0] r_py [4];
    t_xform             r_s3;
    t_xform             r_s4;
    t_bound             r_bnd [NUM_BOUNDS];

    assign w_xs  = {{15{r_s2.x[31]}}, r_s2.x, 17'b0};
    assign w_ys  = {{15{r_s2.y[31]}}, r_s2.y, 17'b0};
    assign w_cwq = {17'b0, r_cw, 16'b0};
    assign w_chq = {17'b0, r_ch, 16'b0};
    assign w_bx  = {17'b0, r_fw_s, 32'b0};
    assign w_by  = {17'b0, r_fh_s, 32'b0};

    for (genvar k = 0; k < 4; k++) begin : g_corner
        // corners in order (-,-), (+,-), (+,+), (-,+)
        localparam logic SXN = (k == 0) || (k == 3);
        localparam logic SYN = (k < 2);
        logic signed [63:0] n_px;
        logic signed [63:0] n_py;
        logic signed [63:0] w_idvx;
        logic signed [63:0] w_idvy;

        assign n_px   = (SXN ? -r_acw : r_acw) + (SYN ? -r_bch : r_bch) + w_xs;
        assign n_py   = (SXN ? r_bcw : -r_bcw) + (SYN ? -r_ach : r_ach) + w_ys;
        assign w_idvx = SXN ? -w_cwq : w_cwq;
        assign w_idvy = SYN ? -w_chq : w_chq;

        always_ff @(posedge i_clk) begin
            r_px[k]      <= n_px;
            r_py[k]      <= n_py;
            r_bnd[2*k]   <= f_bound(r_px[k], w_idvx, -w_bx, w_bx);
            r_bnd[2*k+1] <= f_bound(r_py[k], w_idvy, -w_by, w_by);
        end
    end

    logic signed [63:0] w_a64;
    logic signed [63:0] w_b64;
    logic signed [63:0] w_skew;

    assign w_a64  = 64'(r_s3.a);
    assign w_b64  = 64'(r_s3.b);
    assign w_skew = {47'b0, r_max_skew};

    always_ff @(posedge i_clk) begin
        r_s3 <= r_s2;
        r_s4 <= r_s3;
        r_bnd[NUM_BOUNDS-2] <= f_bound(w_a64, ONE_Q16, {33'b0, r_min_scale},
                                       {33'b0, r_max_scale});
        r_bnd[NUM_BOUNDS-1] <= f_bound(w_b64, 64'sd0, -w_skew, w_skew);
    end

    // per-bound shrink factors
    logic [16:0] w_fac [NUM_BOUNDS];

    for (genvar k = 0; k < NUM_BOUNDS; k++) begin : g_div
        cfs_div u_div (
            .i_clk    (i_clk),
            .i_bound  (r_bnd[k]),
            .o_factor (w_fac[k])
        );
    end

    // transform rides alongside the dividers
    t_xform r_dly [DLY_LEN];
    always_ff @(posedge i_clk) begin
        r_dly[0] <= r_s4;
        for (int i = 1; i < DLY_LEN; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    // minimum over the factors, two stages
    logic [16:0] r_m1 [NUM_MIN1];
    logic [16:0] n_lam;
    logic [16:0] r_lam;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_MIN1; i++) begin
            r_m1[i] <= (w_fac[2*i+1] < w_fac[2*i]) ? w_fac[2*i+1] : w_fac[2*i];
        end
    end

    always_comb begin
        n_lam = r_m1[0];
        for (int i = 1; i < NUM_MIN1; i++) begin
            if (r_m1[i] < n_lam) begin
                n_lam = r_m1[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lam <= n_lam;
    end

    // scale toward identity; lambda of one reproduces the input exactly
    logic signed [17:0] w_lam_s;
    logic signed [32:0] w_am1;
    logic signed [49:0] r_p_x;
    logic signed [49:0] r_p_y;
    logic signed [50:0] r_p_a;
    logic signed [49:0] r_p_b;
    logic [16:0]        r_lam_p;
    logic               r_last_p;

    assign w_lam_s = signed'({1'b0, r_lam});
    assign w_am1   = 33'(r_dly[DLY_LEN-1].a) - 33'sd65536;

    always_ff @(posedge i_clk) begin
        r_p_x    <= r_dly[DLY_LEN-1].x * w_lam_s;
        r_p_y    <= r_dly[DLY_LEN-1].y * w_lam_s;
        r_p_a    <= w_am1 * w_lam_s;
        r_p_b    <= r_dly[DLY_LEN-1].b * w_lam_s;
        r_lam_p  <= r_lam;
        r_last_p <= r_dly[DLY_LEN-1].last;
    end

    // output register; arithmetic shift gives floor
    logic signed [31:0] r_out_x;
    logic signed [31:0] r_out_y;
    logic signed [31:0] r_out_a;
    logic signed [31:0] r_out_b;
    logic [16:0]        r_fac_o;
    logic               r_shr_o;
    logic               r_last_o;

    always_ff @(posedge i_clk) begin
        r_out_x  <= r_p_x[47:16];
        r_out_y  <= r_p_y[47:16];
        r_out_a  <= r_p_a[47:16] + 32'h0001_0000;
        r_out_b  <= r_p_b[47:16];
        r_fac_o  <= r_lam_p;
        r_shr_o  <= r_lam_p < LAM_ONE;
        r_last_o <= r_last_p;
    end

    assign o_valid         = r_vld[PIPE_DEPTH-1];
    assign o_out_x         = r_out_x;
    assign o_out_y         = r_out_y;
    assign o_out_a         = r_out_a;
    assign o_out_b         = r_out_b;
    assign o_shrink_factor = r_fac_o;
    assign o_was_shrunk    = r_shr_o;
    assign o_last_out      = r_last_o;

endmodule
`default_nettype wire

>>> sv/cfs_checker.sv
`default_nettype none
`include "crop_feasibility_shrink_core_defines.svh"
module cfs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic signed [31:0] i_shift_x,
    input logic               i_last_frame,
    input logic               o_valid,
    input logic signed [31:0] o_out_x,
    input logic [16:0]        o_shrink_factor,
    input logic               o_was_shrunk,
    input logic               o_last_out
);
    import cfs_pkg::*;

    `CFS_ASSERT_IMP(a_origin, o_valid, $past(start && !busy, PIPE_DEPTH), "result without a start")
    `CFS_ASSERT_NEVER(a_range, o_valid && (o_shrink_factor > LAM_ONE), "factor above one")
    `CFS_ASSERT_IMP(a_flag, o_valid, o_was_shrunk == (o_shrink_factor != LAM_ONE), "flag mismatch")
    `CFS_ASSERT_IMP(a_last, o_valid, o_last_out == $past(i_last_frame, PIPE_DEPTH), "marker lost")
    `CFS_ASSERT_IMP(a_keep, o_valid && !o_was_shrunk, o_out_x == $past(i_shift_x, PIPE_DEPTH), "x changed")

endmodule

bind crop_feasibility_shrink_core cfs_checker u_cfs_checker (.*);
`default_nettype wire
